// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Types and constants shared by the preemptive priority scheduler modules.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TIME_W      = 32;

	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic MODE_FCFS = 1'b0;
	localparam logic MODE_PRIO = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [15:0] job_id;
		logic [15:0] burst;
		logic [7:0]  prio_level;
	} req_t;

	typedef struct packed {
		logic              admit_ok;
		logic              finished;
		logic [15:0]       done_id;
		logic [TIME_W-1:0] done_arrival;
		logic [TIME_W-1:0] done_finish;
		logic [TIME_W-1:0] done_wait;
		logic              idle_tick;
		logic [CNT_W-1:0]  occupancy;
	} rsp_t;

	// one ready queue entry
	typedef struct packed {
		logic [15:0]       id;
		logic [TIME_W-1:0] arrival;
		logic [15:0]       burst;
		logic [7:0]        prio;
		logic [15:0]       remaining;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		slot_t             wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT,
		ST_INSERT,
		ST_HEAD,
		ST_DEQ,
		ST_WAIT,
		ST_EMIT
	} pps_state_t;

endpackage

// ===== src/pps_ram.sv =====
// ----------------------------------------------------------------------------
// pps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/pps_ctrl.sv =====
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer and datapath: walks the queue RAM one entry per cycle for the
// priority scan, insert shift and dequeue shift, and builds each response.
// ----------------------------------------------------------------------------
module pps_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  pps_pkg::req_t   req,
	output logic            req_stall,
	input  logic            mode,
	input  logic            rsp_free,
	output logic            rsp_load,
	output pps_pkg::rsp_t   rsp_next,
	output pps_pkg::ram_req_t ram,
	input  pps_pkg::slot_t  rd_data
);
	import pps_pkg::*;

	pps_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [TIME_W-1:0] now_q, now_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [ADDR_W-1:0] pos_q, pos_d;
	slot_t             new_q, new_d;
	rsp_t              res_q, res_d;
	logic [TIME_W:0]   sum_q, sum_d;
	logic [TIME_W+1:0] diff;
	slot_t             dec_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			now_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			now_q   <= now_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		pos_q <= pos_d;
		new_q <= new_d;
		res_q <= res_d;
		sum_q <= sum_d;
	end

	// negative wait (only after time saturation) shows up as a set sign bit
	assign diff = {2'b00, now_q} - {1'b0, sum_q};

	always_comb begin
		dec_slot           = rd_data;
		dec_slot.remaining = rd_data.remaining - 16'd1;
	end

	always_comb begin
		rsp_next           = res_q;
		rsp_next.occupancy = count_q;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		now_d     = now_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		new_d     = new_q;
		res_d     = res_q;
		sum_d     = sum_q;
		ram       = '0;
		rsp_load  = 1'b0;
		req_stall = (state_q != ST_IDLE);

		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					res_d               = '0;
					new_d.id            = req.job_id;
					new_d.arrival       = now_q;
					new_d.burst         = req.burst;
					new_d.prio          = req.prio_level;
					new_d.remaining     = req.burst;
					if (req.cmd == CMD_ADMIT) begin
						if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							state_d = ST_EMIT;
						end else if (count_q == '0 || mode == MODE_FCFS) begin
							pos_d   = count_q[ADDR_W-1:0];
							state_d = ST_INSERT;
						end else begin
							ram.raddr = '0;
							idx_d     = '0;
							state_d   = ST_SCAN;
						end
					end else begin
						if (now_q != '1) begin
							now_d = now_q + TIME_W'(1);
						end
						if (count_q == '0) begin
							res_d.idle_tick = 1'b1;
							state_d         = ST_EMIT;
						end else begin
							ram.raddr = '0;
							state_d   = ST_HEAD;
						end
					end
				end
			end

			// first entry with worse priority than the new job, else the rear
			ST_SCAN: begin
				if (rd_data.prio > new_q.prio) begin
					pos_d     = idx_q;
					ram.raddr = ADDR_W'(count_q - CNT_W'(1));
					idx_d     = count_q[ADDR_W-1:0];
					state_d   = ST_SHIFT;
				end else if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
					pos_d   = count_q[ADDR_W-1:0];
					state_d = ST_INSERT;
				end else begin
					ram.raddr = idx_q + ADDR_W'(1);
					idx_d     = idx_q + ADDR_W'(1);
				end
			end

			// move entries one place toward the rear, last one first
			ST_SHIFT: begin
				ram.we    = 1'b1;
				ram.waddr = idx_q;
				ram.wdata = rd_data;
				if (idx_q - ADDR_W'(1) == pos_q) begin
					state_d = ST_INSERT;
				end else begin
					ram.raddr = idx_q - ADDR_W'(2);
					idx_d     = idx_q - ADDR_W'(1);
				end
			end

			ST_INSERT: begin
				ram.we         = 1'b1;
				ram.waddr      = pos_q;
				ram.wdata      = new_q;
				count_d        = count_q + CNT_W'(1);
				res_d.admit_ok = 1'b1;
				state_d        = ST_EMIT;
			end

			ST_HEAD: begin
				if (rd_data.remaining <= 16'd1) begin
					res_d.finished     = 1'b1;
					res_d.done_id      = rd_data.id;
					res_d.done_arrival = rd_data.arrival;
					res_d.done_finish  = now_q;
					sum_d = {1'b0, rd_data.arrival} + {{(TIME_W - 15){1'b0}}, rd_data.burst};
					if (count_q > CNT_W'(1)) begin
						ram.raddr = ADDR_W'(1);
						idx_d     = ADDR_W'(1);
						state_d   = ST_DEQ;
					end else begin
						state_d = ST_WAIT;
					end
				end else begin
					ram.we    = 1'b1;
					ram.waddr = '0;
					ram.wdata = dec_slot;
					state_d   = ST_EMIT;
				end
			end

			// move entries one place toward the head
			ST_DEQ: begin
				ram.we    = 1'b1;
				ram.waddr = idx_q - ADDR_W'(1);
				ram.wdata = rd_data;
				if (CNT_W'(idx_q) + CNT_W'(1) == count_q) begin
					state_d = ST_WAIT;
				end else begin
					ram.raddr = idx_q + ADDR_W'(1);
					idx_d     = idx_q + ADDR_W'(1);
				end
			end

			ST_WAIT: begin
				res_d.done_wait = diff[TIME_W+1] ? '0 : diff[TIME_W-1:0];
				count_d         = count_q - CNT_W'(1);
				state_d         = ST_EMIT;
			end

			ST_EMIT: begin
				if (rsp_free) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Ready queue job scheduler with priority or first come first served order.
// ----------------------------------------------------------------------------
// One request is handled at a time; req_stall stays high until its response
// is loaded into the output register. The queue lives in a RAM with one read
// and one write port, and the sequencer walks it one entry per cycle, so the
// cost grows with occupancy N: a refused admit or an idle tick goes straight
// to the response; an FCFS admit or a tick that does not finish its job does
// one RAM write; a priority admit scans up to the insert point, then shifts
// the tail when the job does not go at the rear; a tick that finishes the
// head job shifts the rest toward the head. A response may also wait on
// rsp_stall. The response sits in an output register, so a new request is
// taken while it waits for transfer. The policy register takes a write only
// while the sequencer is idle and no request is offered.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pps_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pps_pkg::rsp_t rsp,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic          cfg_data
);
	import pps_pkg::*;

	logic                mode_q;
	logic                rsp_valid_q;
	rsp_t                rsp_q;
	logic                rsp_free;
	logic                rsp_load;
	rsp_t                rsp_next;
	ram_req_t            ram_req;
	logic [SLOT_W-1:0]   ram_rdata;

	assign cfg_ready = !req_stall && !req_valid;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_PRIO;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q <= cfg_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	pps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.mode      (mode_q),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.rsp_next  (rsp_next),
		.ram       (ram_req),
		.rd_data   (ram_rdata)
	);

	pps_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== src/pps_checker.sv =====
// ----------------------------------------------------------------------------
// pps_checker
// Port level checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pps_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input pps_pkg::rsp_t rsp
);
	import pps_pkg::*;

	// a request transfer always leaves the block busy
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken without going busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.admit_ok, rsp.finished, rsp.idle_tick}))
		else $error("response reports more than one outcome");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.finished |-> rsp.done_id == '0 && rsp.done_arrival == '0
			&& rsp.done_finish == '0 && rsp.done_wait == '0)
		else $error("completion fields set without a finished job");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.occupancy <= CNT_W'(QUEUE_DEPTH)
			&& (!rsp.finished || rsp.done_finish >= rsp.done_arrival))
		else $error("occupancy or completion time out of range");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the preemptive priority scheduler against a cycle-free predictor of
// its ready queue. Each accepted request is scheduled in the predictor and
// the expected response is queued. Every response transfer is then checked
// field by field against the oldest expected one. The stimulus has a few
// directed cases, then random admit/tick traffic in both policy modes, with
// idle and stall gaps on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import pps_pkg::*;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	logic  cfg_data  = 1'b0;

	preemptive_priority_scheduler DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// predicted scheduler state
	logic [TIME_W-1:0] clock_now = '0;
	int                job_count = 0;
	slot_t             ready_q[QUEUE_DEPTH];
	logic              policy = MODE_PRIO;

	rsp_t pending_reports[$];
	int   mismatches = 0;
	bit   offering = 1'b0;
	int   req_idle_pct = 20;
	int   rsp_idle_pct = 20;

	// long response hold-off, requested by the stimulus, served by the stall process
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;
	localparam int HOLD_CYCLES = 300;

	function automatic rsp_t schedule_step(input req_t item);
		rsp_t        r;
		int          pos;
		int          k;
		logic [32:0] due;
		r = '0;
		if (item.cmd == CMD_ADMIT) begin
			if (job_count < QUEUE_DEPTH) begin
				if (policy == MODE_FCFS || job_count == 0) begin
					pos = job_count;
				end else if (ready_q[0].prio > item.prio_level) begin
					pos = 0;
				end else begin
					// scan stops at the first worse job after the head, sorted or not
					pos = 1;
					while (pos < job_count && ready_q[pos].prio <= item.prio_level)
						pos++;
				end
				for (k = job_count; k > pos; k--)
					ready_q[k] = ready_q[k-1];
				ready_q[pos].id        = item.job_id;
				ready_q[pos].arrival   = clock_now;
				ready_q[pos].burst     = item.burst;
				ready_q[pos].prio      = item.prio_level;
				ready_q[pos].remaining = item.burst;
				job_count++;
				r.admit_ok = 1'b1;
			end
		end else begin
			if (clock_now != '1)
				clock_now++;
			if (job_count == 0) begin
				r.idle_tick = 1'b1;
			end else if (ready_q[0].remaining <= 1) begin
				r.finished     = 1'b1;
				r.done_id      = ready_q[0].id;
				r.done_arrival = ready_q[0].arrival;
				r.done_finish  = clock_now;
				due = {1'b0, ready_q[0].arrival} + 33'(ready_q[0].burst);
				r.done_wait = (due > {1'b0, clock_now}) ? '0 : clock_now - due[31:0];
				for (k = 1; k < job_count; k++)
					ready_q[k-1] = ready_q[k];
				job_count--;
			end else begin
				ready_q[0].remaining--;
			end
		end
		r.occupancy = CNT_W'(job_count);
		return r;
	endfunction

	function automatic void flag_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("  %s mismatch: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			hold_served <= hold_asked;
			hold_left   <= HOLD_CYCLES;
			rsp_stall   <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	always @(posedge clk) begin : check_report
		rsp_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_reports.size() == 0) begin
				if (mismatches < 10)
					$display("  response transfer with nothing expected: %h", rsp);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				flag_field("admit_ok", 32'(want.admit_ok), 32'(rsp.admit_ok));
				flag_field("finished", 32'(want.finished), 32'(rsp.finished));
				flag_field("done_id", 32'(want.done_id), 32'(rsp.done_id));
				flag_field("done_arrival", want.done_arrival, rsp.done_arrival);
				flag_field("done_finish", want.done_finish, rsp.done_finish);
				flag_field("done_wait", want.done_wait, rsp.done_wait);
				flag_field("idle_tick", 32'(want.idle_tick), 32'(rsp.idle_tick));
				flag_field("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
			end
		end
	end

	task automatic issue_item(input req_t item);
		int gap;
		gap = ($urandom_range(99) < req_idle_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0 && offering) begin
			req_valid <= 1'b0;
			offering = 1'b0;
		end
		repeat (gap) @(posedge clk);
		req_valid <= 1'b1;
		req       <= item;
		offering = 1'b1;
		do @(posedge clk); while (req_stall);
		pending_reports.push_back(schedule_step(item));
	endtask

	task automatic pause_sender();
		if (offering) begin
			req_valid <= 1'b0;
			offering = 1'b0;
		end
		do @(posedge clk); while (pending_reports.size() != 0);
	endtask

	task automatic write_policy(input logic mode);
		pause_sender();
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		policy = mode;
	endtask

	task automatic admit(input logic [15:0] id, input logic [15:0] burst, input logic [7:0] prio);
		req_t item;
		item.cmd        = CMD_ADMIT;
		item.job_id     = id;
		item.burst      = burst;
		item.prio_level = prio;
		issue_item(item);
	endtask

	task automatic tick();
		req_t item;
		// job fields are don't-care on a tick, so fill them with noise
		item            = req_t'({$urandom, $urandom});
		item.cmd        = CMD_TICK;
		issue_item(item);
	endtask

	task automatic run_traffic(input int count, input int admit_pct);
		int n;
		int pick;
		logic [7:0]  prio;
		logic [15:0] burst;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(99) < admit_pct) begin
				// crowd priorities into a few values now and then so ties happen
				prio = $urandom_range(1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
				pick = $urandom_range(99);
				if (pick < 5)
					burst = '0;
				else if (pick < 12)
					burst = 16'($urandom_range(7, 40));
				else
					burst = 16'($urandom_range(1, 6));
				admit(16'($urandom), burst, prio);
			end else begin
				tick();
			end
		end
	endtask

	task automatic test_empty_and_preempt();
		tick();
		admit(16'h0000, 16'd2, 8'hFF);
		admit(16'hFFFF, 16'd1, 8'h00);
		admit(16'h1234, 16'd0, 8'h00);
		repeat (5) tick();
	endtask

	task automatic test_unsorted_queue();
		write_policy(MODE_FCFS);
		admit(16'h00C8, 16'd1, 8'd200);
		admit(16'h000A, 16'd1, 8'd10);
		admit(16'h0064, 16'd1, 8'd100);
		write_policy(MODE_PRIO);
		admit(16'h0032, 16'd1, 8'd50);
		admit(16'h0096, 16'd1, 8'd150);
	endtask

	task automatic test_full_queue();
		while (job_count < QUEUE_DEPTH)
			admit(16'($urandom), 16'($urandom_range(1, 3)), 8'($urandom));
		admit(16'hBEEF, 16'd1, 8'h00);
	endtask

	task automatic test_priority_traffic();
		run_traffic(100, 40);
	endtask

	task automatic test_fcfs_traffic();
		write_policy(MODE_FCFS);
		run_traffic(100, 55);
	endtask

	task automatic test_output_backpressure();
		write_policy(MODE_PRIO);
		hold_asked++;
		req_idle_pct = 0;
		run_traffic(60, 60);
		req_idle_pct = 20;
	endtask

	task automatic test_no_idle();
		write_policy(MODE_FCFS);
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		run_traffic(80, 50);
		req_idle_pct = 20;
		rsp_idle_pct = 20;
	endtask

	task automatic test_long_job();
		write_policy(MODE_PRIO);
		run_traffic(60, 30);
		while (job_count > 0)
			tick();
		// largest burst, left running at the head
		admit(16'($urandom), 16'hFFFF, 8'hFF);
		repeat (4) tick();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_preempt();
		test_unsorted_queue();
		test_full_queue();
		test_priority_traffic();
		test_fcfs_traffic();
		test_output_backpressure();
		test_no_idle();
		test_long_job();
		pause_sender();
		repeat (25) @(posedge clk);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("preemptive_priority_scheduler verification clean");
		end else begin
			$display("preemptive_priority_scheduler verification failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("preemptive_priority_scheduler verification failed");
		$finish;
	end

endmodule
